// ----- hdl/radix_number_formatter_assert.svh -----
// assertion macros for the radix number formatter rtl
// depends on clk_i and rst_ni being present in the including module
`ifndef RADIX_NUMBER_FORMATTER_ASSERT_SVH
`define RADIX_NUMBER_FORMATTER_ASSERT_SVH

`ifndef SYNTHESIS
// implication checked on every rising clock edge outside reset
`define RNF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// consequence checked in the cycle after the antecedent
`define RNF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RNF_ASSERT_IMP(label, ante, cons, msg)
`define RNF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/rnf_pkg.sv -----
// shared types and constants for the radix number formatter
// no dependencies
package rnf_pkg;

  localparam int unsigned MAX_WIDTH = 32;
  localparam int unsigned LEN_W     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned POS_W     = $clog2(MAX_WIDTH);
  localparam int unsigned REQ_W     = 6;
  localparam int unsigned WANT_W    = (LEN_W > REQ_W) ? LEN_W : REQ_W;
  localparam int unsigned NUM_W     = 32;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    RADIX_DEC  = 2'd0,
    RADIX_HEX  = 2'd1,
    RADIX_OCT  = 2'd2,
    RADIX_NONE = 2'd3
  } radix_e;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] character;
    logic              last;
  } emit_t;

endpackage

// ----- hdl/rnf_sub_unit.sv -----
// shared compare and subtract unit of the radix number formatter
// depends on rnf_pkg
module rnf_sub_unit (
  input  logic [rnf_pkg::NUM_W-1:0] a_i,
  input  logic [rnf_pkg::NUM_W-1:0] b_i,
  output logic                      ge_o,
  output logic [rnf_pkg::NUM_W-1:0] diff_o
);
  import rnf_pkg::*;

  logic [NUM_W:0] wide_diff;

  // borrow out of the subtraction gives the compare
  assign wide_diff = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o      = ~wide_diff[NUM_W];
  assign diff_o    = wide_diff[NUM_W-1:0];

endmodule

// ----- hdl/rnf_seq.sv -----
// digit sequencer: counts natural digits, then produces one character per digit
// depends on rnf_pkg, rnf_sub_unit and radix_number_formatter_assert.svh
`include "radix_number_formatter_assert.svh"

module rnf_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rnf_pkg::radix_e           radix_i,
  input  logic [rnf_pkg::NUM_W-1:0] number_i,
  input  logic [rnf_pkg::REQ_W-1:0] min_width_i,
  input  logic                      out_free_i,
  output rnf_pkg::emit_t            emit_o
);
  import rnf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_EMIT
  } state_e;

  state_e             state_q, state_d;
  radix_e             radix_q, radix_d;
  logic [NUM_W-1:0]   rem_q, rem_d;
  logic [LEN_W-1:0]   want_q, want_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [3:0]         dig_q, dig_d;

  logic [NUM_W-1:0]   thr;
  logic               ge;
  logic [NUM_W-1:0]   diff;
  logic               dec_step;
  logic [3:0]         digit;
  logic [LEN_W-1:0]   nat;
  logic [LEN_W-1:0]   len;
  logic [WANT_W-1:0]  want_ext;
  logic [LEN_W-1:0]   want_sat;
  logic               accept;
  logic               emit_fire;

  // powers of ten for decimal, powers of the radix for the digit count scan
  function automatic logic [NUM_W-1:0] thr_value(radix_e r, logic [3:0] idx);
    logic [NUM_W-1:0] res;
    res = '1;
    case (r)
      RADIX_DEC: begin
        case (idx)
          4'd0: res = 32'd1;
          4'd1: res = 32'd10;
          4'd2: res = 32'd100;
          4'd3: res = 32'd1000;
          4'd4: res = 32'd10000;
          4'd5: res = 32'd100000;
          4'd6: res = 32'd1000000;
          4'd7: res = 32'd10000000;
          4'd8: res = 32'd100000000;
          4'd9: res = 32'd1000000000;
          default: res = '1;
        endcase
      end
      RADIX_HEX: begin
        if (idx < 4'd8) res = NUM_W'(1) << {idx[2:0], 2'b00};
      end
      RADIX_OCT: begin
        if (idx < 4'd11) res = NUM_W'(1) << ({2'b00, idx} + {1'b0, idx, 1'b0});
      end
      default: res = '1;
    endcase
    return res;
  endfunction

  function automatic logic [3:0] hex_digit(logic [NUM_W-1:0] v, logic [2:0] idx);
    logic [NUM_W-1:0] sh;
    sh = v >> {idx, 2'b00};
    return sh[3:0];
  endfunction

  function automatic logic [3:0] oct_digit(logic [NUM_W-1:0] v, logic [3:0] idx);
    logic [NUM_W:0] sh;
    sh = {1'b0, v} >> ({2'b00, idx} + {1'b0, idx, 1'b0});
    return {1'b0, sh[2:0]};
  endfunction

  function automatic logic [CHAR_W-1:0] glyph(logic [3:0] d);
    logic [CHAR_W-1:0] res;
    if (d < 4'd10) res = CHAR_W'(8'h30) + CHAR_W'(d);
    else           res = CHAR_W'(8'h41) + CHAR_W'(d - 4'd10);
    return res;
  endfunction

  rnf_sub_unit u_sub (
    .a_i    (rem_q),
    .b_i    (thr),
    .ge_o   (ge),
    .diff_o (diff)
  );

  assign thr        = thr_value(radix_q, pos_q[3:0]);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign dec_step   = (radix_q == RADIX_DEC) && (pos_q < POS_W'(10)) && ge;

  always_comb begin
    digit = 4'd0;
    case (radix_q)
      RADIX_DEC: if (pos_q < POS_W'(10)) digit = dig_q;
      RADIX_HEX: if (pos_q < POS_W'(8))  digit = hex_digit(rem_q, pos_q[2:0]);
      RADIX_OCT: if (pos_q < POS_W'(11)) digit = oct_digit(rem_q, pos_q[3:0]);
      default:   digit = 4'd0;
    endcase
  end

  // saturate the requested width
  assign want_ext = WANT_W'(min_width_i);
  assign want_sat = (want_ext > WANT_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH)
                                                    : LEN_W'(want_ext);

  assign nat = ge ? (LEN_W'(pos_q) + LEN_W'(1)) : LEN_W'(1);
  assign len = (want_q > nat) ? want_q : nat;

  assign emit_fire        = (state_q == ST_EMIT) && !dec_step && out_free_i;
  assign emit_o.valid     = emit_fire;
  assign emit_o.character = glyph(digit);
  assign emit_o.last      = (pos_q == '0);

  always_comb begin
    state_d = state_q;
    radix_d = radix_q;
    rem_d   = rem_q;
    want_d  = want_q;
    pos_d   = pos_q;
    dig_d   = dig_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && radix_i != RADIX_NONE) begin
          state_d = ST_COUNT;
          radix_d = radix_i;
          rem_d   = number_i;
          want_d  = want_sat;
          dig_d   = 4'd0;
          case (radix_i)
            RADIX_DEC: pos_d = POS_W'(9);
            RADIX_HEX: pos_d = POS_W'(7);
            default:   pos_d = POS_W'(10);
          endcase
        end
      end
      ST_COUNT: begin
        // scan from the top digit down until the value reaches that position
        if (ge || pos_q == POS_W'(1)) begin
          state_d = ST_EMIT;
          pos_d   = POS_W'(len - LEN_W'(1));
        end else begin
          pos_d = pos_q - POS_W'(1);
        end
      end
      ST_EMIT: begin
        if (dec_step) begin
          rem_d = diff;
          dig_d = dig_q + 4'd1;
        end else if (emit_fire) begin
          dig_d = 4'd0;
          if (pos_q == '0) state_d = ST_IDLE;
          else             pos_d   = pos_q - POS_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q <= radix_d;
    rem_q   <= rem_d;
    want_q  <= want_d;
    pos_q   <= pos_d;
    dig_q   <= dig_d;
  end

  `RNF_ASSERT_IMP(a_emit_needs_room, emit_o.valid, out_free_i, "character emitted into a full output stage")
  `RNF_ASSERT_IMP(a_dec_digit_range, state_q == ST_EMIT && radix_q == RADIX_DEC, dig_q <= 4'd9, "decimal digit above nine")
  `RNF_ASSERT_NEXT(a_last_ends_item, emit_o.valid && emit_o.last, state_q == ST_IDLE, "sequencer busy after last character")
  `RNF_ASSERT_NEXT(a_none_radix_idle, accept && radix_i == RADIX_NONE, state_q == ST_IDLE, "unused radix started a conversion")

endmodule

// ----- hdl/radix_number_formatter.sv -----
// radix number formatter: one number in, one ascii character per transaction out.
// digit count scan from the top position down, then one character per digit:
// hex and octal digits shifted out, decimal digits by repeated subtraction;
// each character is then held in the output register. the input is not ready until
// the last character of an item has entered that register, so items do not overlap.
// reset: asynchronous, active low, clears sequencer state and the output valid.
module radix_number_formatter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rnf_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // number [31:0], min_width [37:32]
  input  logic [1:0]                     s_axis_tuser,  // req_type [1:0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rnf_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // character [6:0]
  output logic                           m_axis_tlast   // last
);
  import rnf_pkg::*;

  emit_t              emit;
  logic               out_free;
  logic               valid_q, valid_d;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  assign out_free = !valid_q || m_axis_tready;

  rnf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .radix_i     (radix_e'(s_axis_tuser)),
    .number_i    (s_axis_tdata[NUM_W-1:0]),
    .min_width_i (s_axis_tdata[NUM_W+REQ_W-1:NUM_W]),
    .out_free_i  (out_free),
    .emit_o      (emit)
  );

  // output register holds a character until its transaction completes
  always_comb begin
    valid_d = valid_q;
    if (emit.valid)         valid_d = 1'b1;
    else if (m_axis_tready) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      char_q <= emit.character;
      last_q <= emit.last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - CHAR_W){1'b0}}, char_q};
  assign m_axis_tlast  = last_q;

endmodule

// ----- bench/tb_radix_number_formatter.sv -----
// self-checking bench for radix_number_formatter: directed and random numbers in three radixes
// depends on rnf_pkg and the radix_number_formatter rtl; predicts every character in-line
module tb_radix_number_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  import rnf_pkg::*;

  typedef struct {
    radix_e      radix;
    logic [31:0] number;
    logic [5:0]  min_width;
    bit          drain;     // hold this request until every pending character has arrived
    int unsigned phase;     // selects the idle mix of both sides
  } fmt_req_t;

  typedef struct {
    logic [CHAR_W-1:0] glyph;
    logic              is_last;
  } digit_t;

  localparam int unsigned N_RANDOM = 102;
  localparam int unsigned MAX_MSGS = 50;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  fmt_req_t    request_q[$];
  digit_t      digit_q[$];
  fmt_req_t    on_bus;
  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 84;
  int unsigned n_requested   = 0;
  int unsigned n_accepted    = 0;
  int unsigned n_errors      = 0;

  radix_number_formatter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // expected characters of one number, most significant digit first
  function automatic void queue_digits(radix_e radix, logic [31:0] value, logic [5:0] min_w);
    int unsigned nat;
    int unsigned len;
    int unsigned pos;
    int unsigned d;
    int unsigned step;
    logic [31:0] rem;
    logic [31:0] scan;
    logic [63:0] pw;
    digit_t      e;
    if (radix == RADIX_NONE) return;
    nat = 1;
    if (radix == RADIX_DEC) begin
      pw = 64'd10;
      while (pw <= value) begin
        nat++;
        pw = pw * 10;
      end
    end else begin
      step = (radix == RADIX_HEX) ? 4 : 3;
      scan = value >> step;
      while (scan != 0) begin
        nat++;
        scan = scan >> step;
      end
    end
    len = (min_w > MAX_WIDTH) ? MAX_WIDTH : min_w;
    if (nat > len) len = nat;
    rem = value;
    for (int k = 0; k < len; k++) begin
      pos = len - 1 - k;
      d   = 0;
      case (radix)
        RADIX_DEC: begin
          // positions above the top power of ten are padding
          if (pos < 10) begin
            pw = 64'd1;
            repeat (pos) pw = pw * 10;
            while (rem >= pw) begin
              rem = rem - pw[31:0];
              d++;
            end
          end
        end
        RADIX_HEX: if (pos < 8) d = (value >> (4 * pos)) & 32'hF;
        RADIX_OCT: if (pos < 11) d = (value >> (3 * pos)) & 32'h7;
        default: ;
      endcase
      e.glyph   = (d < 10) ? CHAR_W'(8'h30 + d) : CHAR_W'(8'h41 + d - 10);
      e.is_last = (k == len - 1);
      digit_q.push_back(e);
    end
  endfunction

  task automatic push_request(radix_e radix, logic [31:0] number, logic [5:0] min_width,
                              bit drain, int unsigned phase);
    fmt_req_t r;
    r.radix     = radix;
    r.number    = number;
    r.min_width = min_width;
    r.drain     = drain;
    r.phase     = phase;
    request_q.push_back(r);
    n_requested++;
  endtask

  // driver
  always @(posedge clk_i) begin
    logic go;
    go = 1'b0;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        queue_digits(on_bus.radix, on_bus.number, on_bus.min_width);
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_q.size() != 0 && !(request_q[0].drain && digit_q.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          on_bus = request_q.pop_front();
          go     = 1'b1;
          case (on_bus.phase)
            0: begin
              send_idle_pct = 15;
              recv_idle_pct = 84;
            end
            1: begin
              send_idle_pct = 84;
              recv_idle_pct = 15;
            end
            default: begin
              send_idle_pct = 0;
              recv_idle_pct = 0;
            end
          endcase
          s_axis_tdata <= {2'b00, on_bus.min_width, on_bus.number};
          s_axis_tuser <= on_bus.radix;
        end
        s_axis_tvalid <= go;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    digit_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (digit_q.size() == 0) begin
          if (n_errors < MAX_MSGS)
            $display("%0t: unexpected transaction, actual char %h last %b",
                     $time, m_axis_tdata, m_axis_tlast);
          n_errors++;
        end else begin
          want = digit_q.pop_front();
          if (m_axis_tdata !== {1'b0, want.glyph} || m_axis_tlast !== want.is_last) begin
            if (n_errors < MAX_MSGS)
              $display("%0t: mismatch, expected char %h last %b, actual char %h last %b",
                       $time, {1'b0, want.glyph}, want.is_last, m_axis_tdata, m_axis_tlast);
            n_errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    radix_e      rx;
    logic [31:0] v;
    logic [31:0] p;
    logic [5:0]  w;
    int unsigned w_sel;

    // directed: field extremes, every radix, saturation, zero width, padding, ignored radix
    push_request(RADIX_DEC, 32'd0,          6'd0,  1'b0, 0);
    push_request(RADIX_DEC, 32'hFFFF_FFFF,  6'd0,  1'b0, 0);
    push_request(RADIX_HEX, 32'hFFFF_FFFF,  6'd0,  1'b0, 0);
    push_request(RADIX_OCT, 32'hFFFF_FFFF,  6'd0,  1'b0, 0);
    push_request(RADIX_HEX, 32'd0,          6'd32, 1'b0, 0);
    push_request(RADIX_DEC, 32'd1234567890, 6'd63, 1'b0, 0);
    push_request(RADIX_OCT, 32'd0,          6'd33, 1'b0, 0);
    push_request(RADIX_NONE, 32'hFFFF_FFFF, 6'd63, 1'b0, 0);
    push_request(RADIX_DEC, 32'd1000000000, 6'd0,  1'b1, 0);
    push_request(RADIX_DEC, 32'd999999999,  6'd1,  1'b0, 0);
    push_request(RADIX_HEX, 32'hABCD_EF01,  6'd12, 1'b0, 0);
    push_request(RADIX_OCT, 32'd8,          6'd1,  1'b0, 0);
    push_request(RADIX_DEC, 32'd9,          6'd2,  1'b0, 0);
    push_request(RADIX_DEC, 32'd10,         6'd0,  1'b0, 0);
    push_request(RADIX_HEX, 32'h10,         6'd0,  1'b0, 0);
    push_request(RADIX_NONE, 32'd0,         6'd0,  1'b0, 0);
    push_request(RADIX_OCT, 32'o7654321,    6'd11, 1'b0, 0);
    push_request(RADIX_HEX, 32'h0123_4567,  6'd8,  1'b0, 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      rx = ($urandom_range(99) < 8) ? RADIX_NONE : radix_e'($urandom_range(2));
      case ($urandom_range(3))
        0: v = $urandom;
        1: v = $urandom >> $urandom_range(31);
        2: v = $urandom_range(99);
        default: begin
          // around a power of ten
          p = 32'd1;
          repeat ($urandom_range(9)) p = p * 10;
          v = p + $urandom_range(2) - 1;
        end
      endcase
      w_sel = $urandom_range(99);
      if (w_sel < 70)      w = 6'($urandom_range(12));
      else if (w_sel < 90) w = 6'($urandom_range(32));
      else                 w = 6'($urandom_range(63, 33));
      push_request(rx, v, w, (i % 40 == 39), (i < 40) ? 0 : (i < 80) ? 1 : 2);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_requested) @(negedge clk_i);
    while (digit_q.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);

    if (n_errors == 0 && digit_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
